// ===== hdl/swa_pkg.sv =====
package swa_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;
  localparam int SLOT_W = 12;

  typedef enum logic [1:0] {
    AGG_AVG = 2'd0,
    AGG_MAX = 2'd1,
    AGG_MIN = 2'd2,
    AGG_SUM = 2'd3
  } agg_mode_t;

  typedef enum logic {
    REG_WINDOW_LEN = 1'b0,
    REG_AGG_MODE   = 1'b1
  } cfg_reg_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
    agg_mode_t         mode;
  } job_t;

endpackage

// ===== hdl/swa_ram.sv =====
module swa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/swa_div.sv =====
module swa_div import swa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              run;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] shreg;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    rem;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem[CNT_W-1:0], shreg[DATA_W-1]};
  assign ge = rem_sh >= {1'b0, dvs};
  assign quotient = neg ? (~shreg + 1'b1) : shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DATA_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[DATA_W-1];
      shreg <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (run) begin
      rem   <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      shreg <= {shreg[DATA_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/swa_front.sv =====
module swa_front import swa_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_sample,
  input  logic [CNT_W-1:0]  window_len,
  input  agg_mode_t         agg_mode,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);

  localparam int PTR_W  = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = FILL_W > CNT_W ? FILL_W : CNT_W;

  logic [PTR_W-1:0]  wp;
  logic [FILL_W-1:0] fill;
  logic [CMP_W-1:0]  fill_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  job_t       queue [2];
  logic       qwr;
  logic       qrd;
  logic [1:0] qcnt;

  assign fill_ext  = CMP_W'(fill);
  assign len_ext   = CMP_W'(window_len);
  assign count     = fill_ext < len_ext ? CNT_W'(fill_ext) : window_len;
  assign in_ready  = qcnt != 2'd2;
  assign push      = in_valid && in_ready;
  assign job_valid = qcnt != 2'd0;
  assign pop       = job_valid && job_ready;
  assign job       = queue[qrd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
      qwr  <= 1'b0;
      qrd  <= 1'b0;
      qcnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp + 1'b1;
        if (fill != FILL_W'(WINDOW_MAX)) begin
          fill <= fill + 1'b1;
        end
        qwr <= ~qwr;
      end
      if (pop) begin
        qrd <= ~qrd;
      end
      if (push && !pop) begin
        qcnt <= qcnt + 1'b1;
      end else if (pop && !push) begin
        qcnt <= qcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[qwr].sample <= in_sample;
      queue[qwr].count  <= count;
      queue[qwr].slot   <= SLOT_W'(wp);
      queue[qwr].mode   <= agg_mode;
    end
  end

endmodule

// ===== hdl/swa_back.sv =====
module swa_back import swa_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  job_t                      job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_aggregate,
  output logic [CNT_W-1:0]          out_count
);

  localparam int PTR_W = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t             state;
  job_t               cur;
  logic [PTR_W-1:0]   ptr;
  logic [PTR_W-1:0]   start_ptr;
  logic [CNT_W-1:0]   issued;
  logic [CNT_W-1:0]   got;
  logic               rd_pend;
  logic [DATA_W-1:0]  total;
  logic signed [DATA_W-1:0] best;
  logic [DATA_W-1:0]  result;

  logic               issue;
  logic               walk_done;
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [DATA_W-1:0]  rdata;
  logic [DATA_W-1:0]  total_next;
  logic signed [DATA_W-1:0] best_next;
  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  quotient;
  logic               out_load;

  swa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (rdata)
  );

  swa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_next),
    .divisor  (cur.count),
    .done     (div_done),
    .quotient (quotient)
  );

  assign job_ready = state == S_IDLE;
  assign issue     = state == S_WALK && issued != cur.count;
  assign walk_done = state == S_WALK && rd_pend && got == cur.count - 1'b1;
  assign div_start = walk_done && cur.mode == AGG_AVG;
  assign total_next = total + rdata;
  assign start_ptr = (PTR_W'(job.slot) == '0) ? PTR_W'(WINDOW_MAX - 1)
                                               : PTR_W'(job.slot) - 1'b1;
  assign out_load  = state == S_FINISH && (!out_valid || out_ready);

  always_comb begin
    best_next = best;
    if (got == '0) begin
      best_next = $signed(rdata);
    end else if (cur.mode == AGG_MAX && $signed(rdata) > best) begin
      best_next = $signed(rdata);
    end else if (cur.mode == AGG_MIN && $signed(rdata) < best) begin
      best_next = $signed(rdata);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = PTR_W'(cur.slot);
    ram_wdata = cur.sample;
    if (state == S_IDLE && job_valid && job.count == '0) begin
      ram_we    = 1'b1;
      ram_waddr = PTR_W'(job.slot);
      ram_wdata = job.sample;
    end else if (walk_done) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur     <= job;
            ptr     <= start_ptr;
            issued  <= '0;
            got     <= '0;
            rd_pend <= 1'b0;
            total   <= '0;
            result  <= '0;
            state   <= (job.count == '0) ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          rd_pend <= issue;
          if (issue) begin
            issued <= issued + 1'b1;
            ptr    <= (ptr == '0) ? PTR_W'(WINDOW_MAX - 1) : ptr - 1'b1;
          end
          if (rd_pend) begin
            total <= total_next;
            best  <= best_next;
            got   <= got + 1'b1;
          end
          if (walk_done) begin
            case (cur.mode)
              AGG_AVG: state <= S_DIVIDE;
              AGG_SUM: begin
                result <= total_next;
                state  <= S_FINISH;
              end
              default: begin
                result <= best_next;
                state  <= S_FINISH;
              end
            endcase
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            result <= quotient;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_aggregate <= result;
            out_count     <= cur.count;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sliding_window_aggregate.sv =====
// Each signed 32-bit sample word on the slave side yields one result word on the
// master side: the average (truncated toward zero), maximum, minimum or wrapping sum
// of up to window_len earlier samples, not counting the new one, together with how
// many samples were covered; an empty history gives 0. The history RAM read port
// delivers one stored sample per cycle during the walk over the covered samples, and
// average mode then runs the one-bit-per-cycle divider on the sum.
// A two-word queue lets the input side take new words while earlier ones are worked
// on and while a finished result waits on the output. Configuration writes must only
// be made while the block is idle.
module sliding_window_aggregate import swa_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] sample_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // [31:0] aggregate, [40:32] samples_counted, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [CNT_W-1:0]         window_len;
  agg_mode_t                agg_mode;
  logic                     job_valid;
  logic                     job_ready;
  job_t                     job;
  logic signed [DATA_W-1:0] out_aggregate;
  logic [CNT_W-1:0]         out_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= CNT_W'(1);
      agg_mode   <= AGG_AVG;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LEN: window_len <= cfg_data;
        REG_AGG_MODE:   agg_mode   <= agg_mode_t'(cfg_data[1:0]);
        default:        window_len <= window_len;
      endcase
    end
  end

  swa_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata),
    .window_len (window_len),
    .agg_mode   (agg_mode),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  swa_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_aggregate (out_aggregate),
    .out_count     (out_count)
  );

  assign m_tdata = {7'd0, out_count, out_aggregate};

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_count <= window_len)
    else $error("Result covers more samples than the window length.");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_count == '0) |-> out_aggregate == '0)
    else $error("Empty history gave a nonzero aggregate.");

  a_job_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.count <= CNT_W'(WINDOW_MAX) || WINDOW_MAX > 511))
    else $error("Queued word covers more samples than the store holds.");

endmodule
